// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the receiver's RTL files.
// Included by each module that checks its own logic; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define SWR_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define SWR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) ante |=> cons) else $error(msg);
`else
`define SWR_ASSERT(lbl, clk, rst_n, prop, msg)
`define SWR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

// ===== rtl/core/swr_pkg.sv =====
// Package of the sliding-window receiver: widths, codes, word types and CRC function.
// No dependencies; imported by every module of the receiver.
`default_nettype none
package swr_pkg;

  localparam int SEQ_W_DEF   = 32;
  localparam int WORD_W      = 32;
  localparam int DATA_W      = 8;
  localparam int WSIZE_W     = 16;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 16;
  localparam int QDEPTH_DEF  = 4;

  localparam logic [CFG_IDX_W-1:0] REG_SELECTIVE_NACK = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_SIZE    = 2'd1;

  localparam logic [WSIZE_W-1:0] WINDOW_SIZE_RST = 16'd4;

  localparam logic [WORD_W-1:0] CRC_POLY = 32'hEDB8_8320;
  localparam logic [WORD_W-1:0] CRC_INIT = 32'hFFFF_FFFF;
  localparam logic [WORD_W-1:0] CNT_MAX  = 32'hFFFF_FFFF;

  typedef enum logic [1:0] {
    KIND_ACKED    = 2'd0,
    KIND_CRC_FAIL = 2'd1,
    KIND_NACK     = 2'd2
  } kind_t;

  typedef struct packed {
    logic [WORD_W-1:0] seq;
    logic              crc_ok;
    logic              retx;
  } mid_t;

  typedef struct packed {
    logic [WORD_W-1:0] reply_seq;
    logic              reply_ack;
    kind_t             reply_kind;
    logic [WORD_W-1:0] window_base;
    logic [WORD_W-1:0] original_count;
    logic [WORD_W-1:0] retransmit_count;
    logic [WORD_W-1:0] last_in_window_seq;
  } res_t;

  function automatic logic [WORD_W-1:0] crc_byte(input logic [WORD_W-1:0] crc,
                                                 input logic [DATA_W-1:0] b);
    logic [WORD_W-1:0] c;
    c = crc ^ {{(WORD_W-DATA_W){1'b0}}, b};
    for (int i = 0; i < DATA_W; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

  function automatic logic [WORD_W-1:0] sat_inc(input logic [WORD_W-1:0] v);
    return (v == CNT_MAX) ? v : v + 32'd1;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/sliding_window_receiver_crc32.sv =====
// Sliding-window receiver with CRC-32 check: a packet's last word is registered into the mid
// queue and its reply into the output queue. One input word and one reply word per cycle
// sustained while no queue is full; the byte-wide CRC step and window compare set the rate.
// Reset is synchronous and active low: it empties both queues, sets the CRC to all ones,
// clears the window start and counters and returns the registers to their defaults.
// Depends on swr_pkg, swr_front, swr_queue and swr_back.
`default_nettype none
module sliding_window_receiver_crc32 import swr_pkg::*; #(
  parameter int SEQ_WIDTH   = SEQ_W_DEF,
  parameter int MIDQ_DEPTH  = QDEPTH_DEF,
  parameter int OUTQ_DEPTH  = QDEPTH_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  input  wire logic                  in_push,
  output logic                       full,
  input  wire logic [DATA_W-1:0]     in_data_byte,
  input  wire logic                  in_has_byte,
  input  wire logic                  in_last_byte,
  input  wire logic [WORD_W-1:0]     in_seq_number,
  input  wire logic [WORD_W-1:0]     in_expected_crc,
  input  wire logic                  in_is_retransmit,
  output logic                       empty,
  input  wire logic                  pop,
  output logic [WORD_W-1:0]          out_reply_seq,
  output logic                       out_reply_ack,
  output logic [1:0]                 out_reply_kind,
  output logic [WORD_W-1:0]          out_window_base,
  output logic [WORD_W-1:0]          out_original_count,
  output logic [WORD_W-1:0]          out_retransmit_count,
  output logic [WORD_W-1:0]          out_last_in_window_seq
);

  logic               sel_nack_r;
  logic [WSIZE_W-1:0] win_size_r;
  logic               mid_push, mid_full, mid_pop, mid_empty;
  mid_t               mid_wdata, mid_rdata;
  logic               res_push, res_full;
  res_t               res_wdata, res_rdata;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sel_nack_r <= 1'b0;
      win_size_r <= WINDOW_SIZE_RST;
    end else if (cfg_valid) begin
      if (cfg_index == REG_SELECTIVE_NACK) begin
        sel_nack_r <= cfg_data[0];
      end
      if (cfg_index == REG_WINDOW_SIZE) begin
        win_size_r <= cfg_data[WSIZE_W-1:0];
      end
    end
  end

  swr_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_push          (in_push),
    .in_data_byte     (in_data_byte),
    .in_has_byte      (in_has_byte),
    .in_last_byte     (in_last_byte),
    .in_seq_number    (in_seq_number),
    .in_expected_crc  (in_expected_crc),
    .in_is_retransmit (in_is_retransmit),
    .in_full          (full),
    .mid_push         (mid_push),
    .mid_wdata        (mid_wdata),
    .mid_full         (mid_full)
  );

  swr_queue #(
    .WIDTH ($bits(mid_t)),
    .DEPTH (MIDQ_DEPTH)
  ) u_midq (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (mid_push),
    .wdata (mid_wdata),
    .full  (mid_full),
    .pop   (mid_pop),
    .rdata (mid_rdata),
    .empty (mid_empty)
  );

  swr_back #(
    .SEQ_WIDTH (SEQ_WIDTH)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .selective_nack (sel_nack_r),
    .window_size    (win_size_r),
    .mid_empty      (mid_empty),
    .mid_rdata      (mid_rdata),
    .mid_pop        (mid_pop),
    .out_push       (res_push),
    .out_data       (res_wdata),
    .out_full       (res_full)
  );

  swr_queue #(
    .WIDTH ($bits(res_t)),
    .DEPTH (OUTQ_DEPTH)
  ) u_outq (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .wdata (res_wdata),
    .full  (res_full),
    .pop   (pop),
    .rdata (res_rdata),
    .empty (empty)
  );

  assign out_reply_seq          = res_rdata.reply_seq;
  assign out_reply_ack          = res_rdata.reply_ack;
  assign out_reply_kind         = res_rdata.reply_kind;
  assign out_window_base        = res_rdata.window_base;
  assign out_original_count     = res_rdata.original_count;
  assign out_retransmit_count   = res_rdata.retransmit_count;
  assign out_last_in_window_seq = res_rdata.last_in_window_seq;

endmodule
`default_nettype wire

// ===== rtl/core/swr_queue.sv =====
// Small first-in first-out queue of flip-flops, used between the stages of the receiver.
// Depends on swr_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module swr_queue import swr_pkg::*; #(
  parameter int WIDTH = 1,
  parameter int DEPTH = QDEPTH_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] wdata,
  output logic                  full,
  input  wire logic             pop,
  output logic [WIDTH-1:0]      rdata,
  output logic                  empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             push_ok, pop_ok;

  assign full    = (count_r == CNT_W'(DEPTH));
  assign empty   = (count_r == '0);
  assign push_ok = push && !full;
  assign pop_ok  = pop && !empty;
  assign rdata   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (push_ok) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop_ok) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    count_nxt = count_r + CNT_W'(push_ok) - CNT_W'(pop_ok);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_ok) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

  `SWR_ASSERT(a_count_bound, clk, rst_n, count_r <= CNT_W'(DEPTH), "queue count beyond depth")
  `SWR_ASSERT(a_no_overflow, clk, rst_n, !(push && full), "word pushed into full queue")

endmodule
`default_nettype wire

// ===== rtl/core/swr_front.sv =====
// Front stage: takes payload words, runs the byte-wide CRC-32 and queues finished packets.
// Depends on swr_pkg.
`default_nettype none
module swr_front import swr_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_push,
  input  wire logic [DATA_W-1:0] in_data_byte,
  input  wire logic              in_has_byte,
  input  wire logic              in_last_byte,
  input  wire logic [WORD_W-1:0] in_seq_number,
  input  wire logic [WORD_W-1:0] in_expected_crc,
  input  wire logic              in_is_retransmit,
  output logic                   in_full,
  output logic                   mid_push,
  output mid_t                   mid_wdata,
  input  wire logic              mid_full
);

  logic [WORD_W-1:0] crc_r, crc_nxt;
  logic [WORD_W-1:0] crc_upd;
  logic              accept;

  assign in_full = mid_full;
  assign accept  = in_push && !mid_full;
  assign crc_upd = in_has_byte ? crc_byte(crc_r, in_data_byte) : crc_r;

  always_comb begin
    crc_nxt = crc_r;
    if (accept) begin
      crc_nxt = in_last_byte ? CRC_INIT : crc_upd;
    end
  end

  assign mid_push         = accept && in_last_byte;
  assign mid_wdata.seq    = in_seq_number;
  assign mid_wdata.crc_ok = ((crc_upd ^ CRC_INIT) == in_expected_crc);
  assign mid_wdata.retx   = in_is_retransmit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r <= CRC_INIT;
    end else begin
      crc_r <= crc_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/swr_back.sv =====
// Back stage: window test, counters and reply building for each finished packet.
// Depends on swr_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module swr_back import swr_pkg::*; #(
  parameter int SEQ_WIDTH = SEQ_W_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               selective_nack,
  input  wire logic [WSIZE_W-1:0] window_size,
  input  wire logic               mid_empty,
  input  wire mid_t               mid_rdata,
  output logic                    mid_pop,
  output logic                    out_push,
  output res_t                    out_data,
  input  wire logic               out_full
);

  localparam int CMP_W = (SEQ_WIDTH > WSIZE_W) ? SEQ_WIDTH : WSIZE_W;

  logic [SEQ_WIDTH-1:0] win_start_r, win_start_nxt;
  logic [SEQ_WIDTH-1:0] latest_r, latest_nxt;
  logic [WORD_W-1:0]    orig_r, orig_nxt;
  logic [WORD_W-1:0]    retx_r, retx_nxt;
  logic [SEQ_WIDTH-1:0] seq_s, seq_off;
  logic                 go, in_win;
  kind_t                kind;

  assign go      = !mid_empty && !out_full;
  assign mid_pop = go;
  assign seq_s   = mid_rdata.seq[SEQ_WIDTH-1:0];
  assign seq_off = seq_s - win_start_r;
  assign in_win  = (CMP_W'(seq_off) < CMP_W'(window_size));

  always_comb begin
    win_start_nxt = win_start_r;
    latest_nxt    = latest_r;
    orig_nxt      = orig_r;
    retx_nxt      = retx_r;
    kind          = KIND_NACK;
    if (in_win) begin
      latest_nxt = seq_s;
      if (mid_rdata.retx) begin
        retx_nxt = sat_inc(retx_r);
      end else begin
        orig_nxt = sat_inc(orig_r);
      end
      if (mid_rdata.crc_ok) begin
        kind          = KIND_ACKED;
        win_start_nxt = win_start_r + SEQ_WIDTH'(1);
      end else begin
        kind = KIND_CRC_FAIL;
      end
    end
  end

  assign out_push                    = go && (in_win || selective_nack);
  assign out_data.reply_seq          = WORD_W'(seq_s);
  assign out_data.reply_ack          = (kind == KIND_ACKED);
  assign out_data.reply_kind         = kind;
  assign out_data.window_base        = WORD_W'(win_start_nxt);
  assign out_data.original_count     = orig_nxt;
  assign out_data.retransmit_count   = retx_nxt;
  assign out_data.last_in_window_seq = WORD_W'(latest_nxt);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_start_r <= '0;
      latest_r    <= '0;
      orig_r      <= '0;
      retx_r      <= '0;
    end else if (go) begin
      win_start_r <= win_start_nxt;
      latest_r    <= latest_nxt;
      orig_r      <= orig_nxt;
      retx_r      <= retx_nxt;
    end
  end

  `SWR_ASSERT_NEXT(a_window_hold, clk, rst_n, !go, $stable(win_start_r), "window moved while idle")
  `SWR_ASSERT(a_ack_kind, clk, rst_n, !out_push || (out_data.reply_ack == (kind == KIND_ACKED)), "ack disagrees with kind")

endmodule
`default_nettype wire

// ===== verif/sliding_window_receiver_crc32_tb.sv =====
// Self-checking testbench for the sliding-window receiver with its CRC-32 check.
// Packets of random payload are sent as words and every reply is checked against an
// in-bench prediction. Depends on swr_pkg and sliding_window_receiver_crc32.
`timescale 1ns / 1ps
module sliding_window_receiver_crc32_tb;
  import swr_pkg::*;

  typedef struct packed {
    logic [DATA_W-1:0] data_byte;
    logic              has_byte;
    logic              last_byte;
    logic [WORD_W-1:0] seq_number;
    logic [WORD_W-1:0] expected_crc;
    logic              is_retransmit;
  } rx_word_t;

  localparam int IDLE_LIMIT    = 2000;
  localparam int SETTLE_CYCLES = 6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  in_push = 1'b0;
  logic                  full;
  logic [DATA_W-1:0]     in_data_byte = '0;
  logic                  in_has_byte = 1'b0;
  logic                  in_last_byte = 1'b0;
  logic [WORD_W-1:0]     in_seq_number = '0;
  logic [WORD_W-1:0]     in_expected_crc = '0;
  logic                  in_is_retransmit = 1'b0;
  logic                  empty;
  logic                  pop = 1'b0;
  logic [WORD_W-1:0]     out_reply_seq;
  logic                  out_reply_ack;
  logic [1:0]            out_reply_kind;
  logic [WORD_W-1:0]     out_window_base;
  logic [WORD_W-1:0]     out_original_count;
  logic [WORD_W-1:0]     out_retransmit_count;
  logic [WORD_W-1:0]     out_last_in_window_seq;

  rx_word_t           tx_words[$];
  res_t               reply_q[$];
  logic [DATA_W-1:0]  payload_q[$];
  res_t               head_reply;

  logic [WORD_W-1:0]  rx_crc = CRC_INIT;
  logic [WORD_W-1:0]  win_start = '0;
  logic [WORD_W-1:0]  orig_seen = '0;
  logic [WORD_W-1:0]  retx_seen = '0;
  logic [WORD_W-1:0]  last_seq = '0;
  logic               sel_nack = 1'b0;
  logic [WSIZE_W-1:0] win_size = WINDOW_SIZE_RST;

  logic [WORD_W-1:0]  gen_base;
  int                 queued_words = 0;
  int                 push_odds = 0;
  int                 pop_odds = 0;
  int                 send_gap = 0;
  int                 pop_gap = 0;
  bit                 send_hold = 1'b0;
  int                 error_count = 0;
  int                 quiet_cycles = 0;

  sliding_window_receiver_crc32 dut (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .cfg_valid              (cfg_valid),
    .cfg_ready              (cfg_ready),
    .cfg_index              (cfg_index),
    .cfg_data               (cfg_data),
    .in_push                (in_push),
    .full                   (full),
    .in_data_byte           (in_data_byte),
    .in_has_byte            (in_has_byte),
    .in_last_byte           (in_last_byte),
    .in_seq_number          (in_seq_number),
    .in_expected_crc        (in_expected_crc),
    .in_is_retransmit       (in_is_retransmit),
    .empty                  (empty),
    .pop                    (pop),
    .out_reply_seq          (out_reply_seq),
    .out_reply_ack          (out_reply_ack),
    .out_reply_kind         (out_reply_kind),
    .out_window_base        (out_window_base),
    .out_original_count     (out_original_count),
    .out_retransmit_count   (out_retransmit_count),
    .out_last_in_window_seq (out_last_in_window_seq)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic logic [WORD_W-1:0] crc32_update(input logic [WORD_W-1:0] crc,
                                                     input logic [DATA_W-1:0] b);
    logic [WORD_W-1:0] c;
    c = crc ^ {24'd0, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  function automatic logic [WORD_W-1:0] payload_crc();
    logic [WORD_W-1:0] c;
    c = CRC_INIT;
    foreach (payload_q[i]) begin
      c = crc32_update(c, payload_q[i]);
    end
    return ~c;
  endfunction

  task automatic predict_reply(input rx_word_t w);
    logic [WORD_W-1:0] crc_final;
    logic [WORD_W-1:0] seq_off;
    logic              answer;
    res_t              r;
    if (w.has_byte) begin
      rx_crc = crc32_update(rx_crc, w.data_byte);
    end
    if (w.last_byte) begin
      crc_final = ~rx_crc;
      rx_crc = CRC_INIT;
      seq_off = w.seq_number - win_start;
      answer = 1'b1;
      r = '0;
      if (seq_off < {16'd0, win_size}) begin
        last_seq = w.seq_number;
        if (w.is_retransmit) begin
          retx_seen = (retx_seen == CNT_MAX) ? retx_seen : retx_seen + 1;
        end else begin
          orig_seen = (orig_seen == CNT_MAX) ? orig_seen : orig_seen + 1;
        end
        if (crc_final == w.expected_crc) begin
          r.reply_ack = 1'b1;
          r.reply_kind = KIND_ACKED;
          win_start = win_start + 1;
        end else begin
          r.reply_ack = 1'b0;
          r.reply_kind = KIND_CRC_FAIL;
        end
      end else if (sel_nack) begin
        r.reply_ack = 1'b0;
        r.reply_kind = KIND_NACK;
      end else begin
        answer = 1'b0;
      end
      if (answer) begin
        r.reply_seq = w.seq_number;
        r.window_base = win_start;
        r.original_count = orig_seen;
        r.retransmit_count = retx_seen;
        r.last_in_window_seq = last_seq;
        reply_q.push_back(r);
      end
    end
  endtask

  task automatic check_field(input string name, input logic [WORD_W-1:0] want,
                             input logic [WORD_W-1:0] got);
    if (got !== want) begin
      error_count++;
      $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_push <= 1'b0;
    end else begin
      if (in_push && !full) begin
        predict_reply(tx_words.pop_front());
      end
      if (!(in_push && full)) begin
        if (send_gap > 0) begin
          send_gap--;
          in_push <= 1'b0;
        end else if (tx_words.size() != 0 && !send_hold) begin
          in_push <= 1'b1;
          in_data_byte <= tx_words[0].data_byte;
          in_has_byte <= tx_words[0].has_byte;
          in_last_byte <= tx_words[0].last_byte;
          in_seq_number <= tx_words[0].seq_number;
          in_expected_crc <= tx_words[0].expected_crc;
          in_is_retransmit <= tx_words[0].is_retransmit;
          if (push_odds != 0 && $urandom_range(1, 100) <= push_odds) begin
            send_gap = $urandom_range(1, 16);
          end
        end else begin
          in_push <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (reply_q.size() == 0) begin
          error_count++;
          $display("%0t: reply word mismatch, expected none, got seq %h kind %0d",
                   $time, out_reply_seq, out_reply_kind);
        end else begin
          head_reply = reply_q.pop_front();
          check_field("reply_seq", head_reply.reply_seq, out_reply_seq);
          check_field("reply_ack", WORD_W'(head_reply.reply_ack), WORD_W'(out_reply_ack));
          check_field("reply_kind", WORD_W'(head_reply.reply_kind), WORD_W'(out_reply_kind));
          check_field("window_base", head_reply.window_base, out_window_base);
          check_field("original_count", head_reply.original_count, out_original_count);
          check_field("retransmit_count", head_reply.retransmit_count,
                      out_retransmit_count);
          check_field("last_in_window_seq", head_reply.last_in_window_seq,
                      out_last_in_window_seq);
        end
      end
      if (pop_gap > 0) begin
        pop_gap--;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
        if (pop_odds != 0 && $urandom_range(1, 100) <= pop_odds) begin
          pop_gap = $urandom_range(1, 16);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_push && !full) || (pop && !empty) || (cfg_valid && cfg_ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles == IDLE_LIMIT) begin
        $display("FAIL sliding_window_receiver_crc32");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_SELECTIVE_NACK: sel_nack = val[0];
      REG_WINDOW_SIZE: win_size = val;
      default: ;
    endcase
  endtask

  task automatic add_packet(input logic [WORD_W-1:0] seq, input logic retx,
                            input logic [WORD_W-1:0] hdr_crc);
    rx_word_t w;
    logic     scramble;
    scramble = 1'($urandom_range(0, 1));
    foreach (payload_q[i]) begin
      if ($urandom_range(0, 15) == 0) begin
        w.data_byte = DATA_W'($urandom_range(0, 255));
        w.has_byte = 1'b0;
        w.last_byte = 1'b0;
        w.seq_number = $urandom;
        w.expected_crc = $urandom;
        w.is_retransmit = 1'($urandom_range(0, 1));
        tx_words.push_back(w);
        queued_words++;
      end
      w.data_byte = payload_q[i];
      w.has_byte = 1'b1;
      w.last_byte = (i == payload_q.size() - 1);
      if (scramble && !w.last_byte) begin
        w.seq_number = $urandom;
        w.expected_crc = $urandom;
        w.is_retransmit = 1'($urandom_range(0, 1));
      end else begin
        w.seq_number = seq;
        w.expected_crc = hdr_crc;
        w.is_retransmit = retx;
      end
      tx_words.push_back(w);
      queued_words++;
    end
    if (payload_q.size() == 0) begin
      w.data_byte = DATA_W'($urandom_range(0, 255));
      w.has_byte = 1'b0;
      w.last_byte = 1'b1;
      w.seq_number = seq;
      w.expected_crc = hdr_crc;
      w.is_retransmit = retx;
      tx_words.push_back(w);
      queued_words++;
    end
  endtask

  task automatic settle();
    do @(negedge clk); while (tx_words.size() != 0 || in_push || reply_q.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic run_phase(input logic sel, input logic [WSIZE_W-1:0] ws, input int words,
                           input int podds, input int qodds, input bit pause);
    int                 first;
    int                 len;
    int                 pick;
    logic [WORD_W-1:0]  seq;
    logic [WORD_W-1:0]  crc;
    logic [CFG_DATA_W-1:0] mode_word;
    mode_word = CFG_DATA_W'($urandom);
    mode_word[0] = sel;
    write_reg(REG_SELECTIVE_NACK, mode_word);
    write_reg(REG_WINDOW_SIZE, ws);
    @(negedge clk);
    push_odds = podds;
    pop_odds = qodds;
    gen_base = win_start;
    first = queued_words;
    while (queued_words - first < words) begin
      payload_q = {};
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(0, 8);
      repeat (len) payload_q.push_back(DATA_W'($urandom_range(0, 255)));
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        seq = gen_base + ((ws == 0) ? $urandom_range(0, 3) : $urandom_range(0, ws - 1));
      end else if (pick < 80) begin
        seq = gen_base + ws + $urandom_range(0, 3);
      end else if (pick < 88) begin
        seq = gen_base - 1 - $urandom_range(0, 3);
      end else begin
        seq = $urandom;
      end
      crc = payload_crc();
      pick = $urandom_range(0, 99);
      if (pick < 15) begin
        crc = crc ^ (32'd1 << $urandom_range(0, 31));
      end else if (pick < 20) begin
        crc = $urandom;
      end
      // A matching checksum inside the window moves the window on, as the receiver will.
      if (crc == payload_crc() && (seq - gen_base) < {16'd0, ws}) begin
        gen_base = gen_base + 1;
      end
      add_packet(seq, 1'($urandom_range(0, 1)), crc);
    end
    if (pause) begin
      do @(negedge clk); while (tx_words.size() > words / 2);
      send_hold = 1'b1;
      do @(negedge clk); while (in_push || reply_q.size() != 0);
      send_hold = 1'b0;
    end
    settle();
  endtask

  initial begin
    logic [WSIZE_W-1:0] ws_pick;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    push_odds = 20;
    pop_odds = 20;

    // Go-back-N with the default window of four.
    payload_q = {};
    add_packet(32'd0, 1'b0, 32'h0000_0000);
    payload_q = {8'h00};
    add_packet(32'd1, 1'b0, payload_crc());
    payload_q = {8'hFF, 8'hFF, 8'hFF};
    add_packet(32'd2, 1'b1, payload_crc());
    payload_q = {};
    for (int i = 0; i < 9; i++) payload_q.push_back(DATA_W'(8'h31 + i));
    add_packet(32'd3, 1'b0, 32'hCBF4_3926);
    payload_q = {8'hA5, 8'h5A};
    add_packet(32'd4, 1'b1, 32'h0000_0000);
    payload_q = {8'h01};
    add_packet(32'hFFFF_FFFF, 1'b0, payload_crc());
    payload_q = {};
    add_packet(32'd8, 1'b1, 32'h0000_0000);
    settle();

    write_reg(REG_SELECTIVE_NACK, 16'h0001);
    @(negedge clk);
    payload_q = {};
    add_packet(32'h8000_0000, 1'b0, 32'hFFFF_FFFF);
    payload_q = {8'h80};
    add_packet(32'd7, 1'b0, payload_crc());
    settle();

    // Writes to unused register indexes must leave the settings alone.
    write_reg(REG_SPARE_A, CFG_DATA_W'($urandom));
    write_reg(REG_SPARE_B, 16'hFFFF);
    @(negedge clk);
    payload_q = {8'h3C};
    add_packet(win_start + 4, 1'b0, payload_crc());
    settle();

    run_phase(1'b1, 16'd1, 260, 25, 25, 1'b0);
    run_phase(1'b0, 16'hFFFF, 260, 10, 40, 1'b0);
    run_phase(1'b1, 16'hFFFF, 260, 0, 15, 1'b0);
    run_phase(1'b1, 16'd0, 120, 30, 10, 1'b0);
    run_phase(1'b0, 16'd0, 60, 20, 20, 1'b0);
    ws_pick = WSIZE_W'($urandom_range(2, 300));
    run_phase(1'b1, ws_pick, 260, 15, 15, 1'b1);
    ws_pick = WSIZE_W'($urandom_range(2, 65534));
    run_phase(1'b0, ws_pick, 260, 20, 0, 1'b0);
    run_phase(1'b1, 16'd4, 260, 0, 0, 1'b0);

    if (error_count == 0) begin
      $display("PASS sliding_window_receiver_crc32");
    end else begin
      $display("FAIL sliding_window_receiver_crc32");
    end
    $finish;
  end

endmodule
